[hdl/pale_pkg.sv]
// ----------------------------------------------------------------------------
// pale_pkg: shared types and constants of the positional array list engine
// Holds the list geometry, opcode and status codes, and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package pale_pkg;

  // list geometry
  localparam int unsigned DEPTH  = 16;
  localparam int unsigned IDX_W  = $clog2(DEPTH);
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = CNT_W + 1;

  // fixed field widths
  localparam int unsigned OP_W   = 3;
  localparam int unsigned POS_W  = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned FIDX_W = 4;
  localparam int unsigned CAP_W  = 5;
  localparam int unsigned ST_W   = 2;

  // register reset value of max_entries
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // opcodes
  typedef enum logic [OP_W-1:0] {
    OP_GET    = 3'd0,
    OP_LOCATE = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_RANGE  = 3'd4
  } op_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_FETCH,
    S_SETUP,
    S_COPY,
    S_PUTV,
    S_DONE
  } state_e;

  // datapath commands
  typedef enum logic [2:0] {
    DP_NOP,
    DP_LOAD,
    DP_FETCH,
    DP_SETUP,
    DP_RUN,
    DP_PUTV,
    DP_FINISH
  } dp_cmd_e;

  // controller to datapath
  typedef struct packed {
    dp_cmd_e cmd;
    status_e status;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            pos_ok;
    logic            ins_ok;
    logic            range_ok;
    logic            full;
    logic            run_done;
    logic            match;
    logic            out_busy;
  } dp_sts_t;

endpackage

[hdl/pale_ctrl.sv]
// ----------------------------------------------------------------------------
// pale_ctrl: operation sequencer
// Decodes the latched item, checks bounds through datapath status, and
// steps the datapath through fetch, copy/scan, value write and result load.
// ----------------------------------------------------------------------------
module pale_ctrl import pale_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  dp_sts_t sts_i,
  output ctl_t    ctl_o
);

  state_e  state_q, state_d;
  status_e status_q, status_d;

  // state and status registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      status_q <= ST_OK;
    end else begin
      state_q  <= state_d;
      status_q <= status_d;
    end
  end

  // next state
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_CHECK;
      end
      S_CHECK: begin
        status_d = ST_OK;
        state_d  = S_DONE;
        case (sts_i.op)
          OP_GET, OP_DELETE: begin
            if (sts_i.pos_ok) state_d = S_FETCH;
            else status_d = ST_RANGE;
          end
          OP_LOCATE: state_d = S_COPY;
          OP_INSERT: begin
            if (sts_i.full) status_d = ST_FULL;
            else if (sts_i.ins_ok) state_d = S_COPY;
            else status_d = ST_RANGE;
          end
          OP_RANGE: begin
            if (sts_i.range_ok) state_d = S_COPY;
            else status_d = ST_RANGE;
          end
          default: status_d = ST_RANGE;
        endcase
      end
      S_FETCH: begin
        if (sts_i.run_done) begin
          state_d = (sts_i.op == OP_GET) ? S_DONE : S_SETUP;
        end
      end
      S_SETUP: state_d = S_COPY;
      S_COPY: begin
        if (sts_i.op == OP_LOCATE && sts_i.match) begin
          state_d = S_DONE;
        end else if (sts_i.run_done) begin
          if (sts_i.op == OP_LOCATE) begin
            status_d = ST_NOTFOUND;
            state_d  = S_DONE;
          end else if (sts_i.op == OP_INSERT) begin
            state_d = S_PUTV;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_PUTV: state_d = S_DONE;
      S_DONE: begin
        if (!sts_i.out_busy) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    ctl_o.cmd    = DP_NOP;
    ctl_o.status = status_q;
    in_stall_o   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) ctl_o.cmd = DP_LOAD;
      end
      S_CHECK: begin
        case (sts_i.op)
          OP_GET, OP_DELETE: begin
            if (sts_i.pos_ok) ctl_o.cmd = DP_FETCH;
          end
          OP_LOCATE: ctl_o.cmd = DP_SETUP;
          OP_INSERT: begin
            if (!sts_i.full && sts_i.ins_ok) ctl_o.cmd = DP_SETUP;
          end
          OP_RANGE: begin
            if (sts_i.range_ok) ctl_o.cmd = DP_SETUP;
          end
          default: ctl_o.cmd = DP_NOP;
        endcase
      end
      S_FETCH: ctl_o.cmd = DP_RUN;
      S_SETUP: ctl_o.cmd = DP_SETUP;
      S_COPY:  ctl_o.cmd = DP_RUN;
      S_PUTV:  ctl_o.cmd = DP_PUTV;
      S_DONE: begin
        if (!sts_i.out_busy) ctl_o.cmd = DP_FINISH;
      end
      default: ctl_o.cmd = DP_NOP;
    endcase
  end

endmodule

[hdl/pale_dpath.sv]
// ----------------------------------------------------------------------------
// pale_dpath: list storage and move engine
// Entry memory with registered read, item latch, bound checks, a pointer
// based copy/scan engine that moves one entry per cycle, and result register.
// ----------------------------------------------------------------------------
module pale_dpath import pale_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  output dp_sts_t                  sts_o,
  input  logic [CAP_W-1:0]         cap_i,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [POS_W-1:0]         first_pos_i,
  input  logic [POS_W-1:0]         last_pos_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [FIDX_W-1:0]        found_index_o,
  output logic [POS_W-1:0]         list_length_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  // latched item
  logic [OP_W-1:0]   op_q;
  logic [POS_W-1:0]  p_q, q_q;
  logic [DATA_W-1:0] v_q;

  // list length
  logic [CNT_W-1:0]  count_q, count_d;

  // move engine
  logic [IDX_W-1:0]  src_q, src_d, dst_q, dst_d, tag_q;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              desc_q, desc_d;
  logic              pend_q, pend_d;
  logic [DATA_W-1:0] rd_data_q, hold_q;

  // result register
  logic                     out_valid_q;
  logic [ST_W-1:0]          status_q;
  logic [DATA_W-1:0]        rdval_q;
  logic [FIDX_W-1:0]        fidx_q;
  logic [POS_W-1:0]         len_q;

  logic [CMP_W-1:0] p_x, q_x, cnt_x, cap_x;
  logic             p_pos, mutating, match, rd_issue;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;

  // bound checks on the latched item
  assign p_x   = CMP_W'(p_q);
  assign q_x   = CMP_W'(q_q);
  assign cnt_x = CMP_W'(count_q);
  assign cap_x = (CMP_W'(cap_i) > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : CMP_W'(cap_i);
  assign p_pos = (p_q != '0);

  assign mutating = (op_q == OP_INSERT) || (op_q == OP_DELETE) || (op_q == OP_RANGE);
  assign match    = pend_q && (op_q == OP_LOCATE) && (rd_data_q == v_q);

  assign sts_o.op       = op_q;
  assign sts_o.pos_ok   = p_pos && (p_x <= cnt_x);
  assign sts_o.ins_ok   = p_pos && (p_x <= cnt_x + CMP_W'(1));
  assign sts_o.range_ok = p_pos && (p_x <= q_x) && (q_x <= cnt_x);
  assign sts_o.full     = (cnt_x >= cap_x);
  assign sts_o.run_done = (left_q == '0) && !pend_q;
  assign sts_o.match    = match;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  // read issue: one entry per cycle, held once a search hits
  assign rd_issue = (ctl_i.cmd == DP_RUN) && (left_q != '0) && !match;

  // memory write select: moved entry or inserted value
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = dst_q;
    mem_wdata = rd_data_q;
    if (ctl_i.cmd == DP_RUN && pend_q && mutating) begin
      mem_we = 1'b1;
    end else if (ctl_i.cmd == DP_PUTV) begin
      mem_we    = 1'b1;
      mem_waddr = IDX_W'(p_q - POS_W'(1));
      mem_wdata = v_q;
    end
  end

  // entry memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_issue) begin
      rd_data_q <= mem[src_q];
      tag_q     <= src_q;
    end
  end

  // pointer engine next values
  always_comb begin
    src_d  = src_q;
    dst_d  = dst_q;
    left_d = left_q;
    desc_d = desc_q;
    pend_d = 1'b0;
    case (ctl_i.cmd)
      DP_FETCH: begin
        src_d  = IDX_W'(p_q - POS_W'(1));
        // drain cycle of a delete writes the fetched entry back in place
        dst_d  = IDX_W'(p_q - POS_W'(1));
        left_d = CNT_W'(1);
        desc_d = 1'b0;
      end
      DP_SETUP: begin
        desc_d = 1'b0;
        case (op_q)
          OP_LOCATE: begin
            src_d  = '0;
            left_d = count_q;
          end
          OP_INSERT: begin
            src_d  = IDX_W'(count_q - CNT_W'(1));
            dst_d  = IDX_W'(count_q);
            left_d = count_q - CNT_W'(p_q) + CNT_W'(1);
            desc_d = 1'b1;
          end
          OP_DELETE: begin
            src_d  = IDX_W'(p_q);
            dst_d  = IDX_W'(p_q - POS_W'(1));
            left_d = count_q - CNT_W'(p_q);
          end
          default: begin
            src_d  = IDX_W'(q_q);
            dst_d  = IDX_W'(p_q - POS_W'(1));
            left_d = count_q - CNT_W'(q_q);
          end
        endcase
      end
      DP_RUN: begin
        if (rd_issue) begin
          src_d  = desc_q ? src_q - IDX_W'(1) : src_q + IDX_W'(1);
          left_d = left_q - CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q && mutating) begin
          dst_d = desc_q ? dst_q - IDX_W'(1) : dst_q + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // length after a successful operation
  always_comb begin
    count_d = count_q;
    if (ctl_i.cmd == DP_FINISH && ctl_i.status == ST_OK) begin
      case (op_q)
        OP_INSERT: count_d = count_q + CNT_W'(1);
        OP_DELETE: count_d = count_q - CNT_W'(1);
        OP_RANGE:  count_d = count_q - CNT_W'(q_q) + CNT_W'(p_q) - CNT_W'(1);
        default:   count_d = count_q;
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      desc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      desc_q  <= desc_d;
      if (ctl_i.cmd == DP_FINISH) out_valid_q <= 1'b1;
      else if (!out_stall_i)      out_valid_q <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q <= src_d;
    dst_q <= dst_d;
    if (ctl_i.cmd == DP_LOAD) begin
      op_q <= opcode_i;
      p_q  <= first_pos_i;
      q_q  <= last_pos_i;
      v_q  <= value_i;
    end
    // keep the removed entry before the gap is closed
    if (ctl_i.cmd == DP_SETUP) hold_q <= rd_data_q;
    if (ctl_i.cmd == DP_FINISH) begin
      status_q <= ctl_i.status;
      len_q    <= POS_W'(count_d);
      rdval_q  <= '0;
      fidx_q   <= '0;
      if (ctl_i.status == ST_OK) begin
        if (op_q == OP_GET)    rdval_q <= rd_data_q;
        if (op_q == OP_DELETE) rdval_q <= hold_q;
        if (op_q == OP_LOCATE) fidx_q  <= FIDX_W'(tag_q);
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign read_value_o  = rdval_q;
  assign found_index_o = fidx_q;
  assign list_length_o = len_q;

endmodule

[hdl/positional_array_list_engine_core.sv]
// Items are handled one at a time: the next item is accepted only after
//   the result of the last one has been loaded into the result register,
//   and the move engine moves one entry per cycle.
// Reset: length 0, max_entries 16, result empty; entries undefined, no clear.
// ----------------------------------------------------------------------------
// positional_array_list_engine_core: top level of the array list engine
// Joins the sequencer and the datapath and holds the max_entries register
// behind the APB-style configuration port.
// ----------------------------------------------------------------------------
module positional_array_list_engine_core import pale_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [OP_W-1:0]          opcode_i,
  input  logic [POS_W-1:0]         first_pos_i,
  input  logic [POS_W-1:0]         last_pos_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [FIDX_W-1:0]        found_index_o,
  output logic [POS_W-1:0]         list_length_o,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [1:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);

  localparam logic [1:0] ADDR_MAX_ENTRIES = 2'd0;

  logic [CAP_W-1:0] cap_q;
  ctl_t             ctl;
  dp_sts_t          sts;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_MAX_ENTRIES) begin
      cap_q <= pwdata[CAP_W-1:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_MAX_ENTRIES) ? 32'(cap_q) : '0;

  pale_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  pale_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cap_i         (cap_q),
    .opcode_i      (opcode_i),
    .first_pos_i   (first_pos_i),
    .last_pos_i    (last_pos_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .read_value_o  (read_value_o),
    .found_index_o (found_index_o),
    .list_length_o (list_length_o)
  );

endmodule

[hdl/pale_checker.sv]
// ----------------------------------------------------------------------------
// pale_checker: port-level checks of the array list engine
// Watches the item and result channels for sequencing and result sanity.
// ----------------------------------------------------------------------------
module pale_checker import pale_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic [ST_W-1:0]          status_o,
  input logic signed [DATA_W-1:0] read_value_o,
  input logic [FIDX_W-1:0]        found_index_o,
  input logic [POS_W-1:0]         list_length_o
);

  // a stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again while an item is in flight");

  // failed operations report no data
  a_fail_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_value_o == '0 && found_index_o == '0)
    else $error("data reported on a failed operation");

  // length never exceeds the array depth
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> list_length_o <= POS_W'(DEPTH))
    else $error("list length beyond depth");

endmodule

bind positional_array_list_engine_core pale_checker u_pale_checker (.*);
